FILE: hw/rtl/cdtt_pkg.sv
// Types and codes shared by the countdown timer table.
package cdtt_pkg;

    localparam int SLOTS_DEF = 64;

    typedef enum logic [2:0] {
        ACT_SCHEDULE   = 3'd0,
        ACT_ADD        = 3'd1,
        ACT_CANCEL     = 3'd2,
        ACT_CANCEL_OWN = 3'd3,
        ACT_QUERY      = 3'd4,
        ACT_TICK       = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        RES_DONE  = 3'd0,
        RES_FIRED = 3'd1,
        RES_QUERY = 3'd2,
        RES_FULL  = 3'd3,
        RES_QUIET = 3'd4
    } result_kind_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] owner_id;
        logic [4:0]  event_kind;
        logic [31:0] timer_tag;
        logic [30:0] start_count;
    } timer_cmd_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] owner_id_out;
        logic [4:0]  event_kind_out;
        logic [31:0] timer_tag_out;
        logic        match_found;
        logic        last;
    } timer_res_t;

    typedef struct packed {
        logic [31:0] owner;
        logic [4:0]  kind;
        logic [31:0] tag;
        logic [30:0] count;
    } timer_entry_t;

endpackage

FILE: hw/rtl/countdown_timer_table.sv
// Countdown timer table: keyed timers with schedule, cancel, query and tick actions.
//
// A transaction is taken when start is high and busy is low. Every transaction then
// walks the whole table once, one slot per clock through the single read port of the
// entry memory, so busy stays high through the walk, the registered read and the
// finish state. The receiver cannot hold results off: each result is shown for
// exactly one cycle with result_valid high and must be taken then. Schedule, add,
// cancel, cancel-all-owner and query give a single result, flagged last, which
// appears in the first cycle that busy is low again. A tick gives one fired result
// per expired timer in ascending slot order while the walk is still going on, the
// final one flagged last; a tick that fires nothing gives one quiet result. New
// timers take the lowest free slot, and a schedule or add that finds none reports
// a full table and stores nothing.
module countdown_timer_table
    import cdtt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  timer_cmd_t cmd,
    output logic       busy,
    output logic       result_valid,
    output timer_res_t result
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Entry memory: owner, kind, tag and count per slot; occupancy lives in flops.
    timer_entry_t entry_mem [SLOTS];

    state_t             state_reg, state_next;
    timer_cmd_t         req_reg, req_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]   proc_idx_reg, proc_idx_next;
    logic               ff_vld_reg, ff_vld_next;
    logic [IDX_W-1:0]   ff_idx_reg, ff_idx_next;
    logic               found_reg, found_next;
    logic               pend_vld_reg, pend_vld_next;
    timer_entry_t       pend_reg, pend_next;
    logic               res_vld_reg, res_vld_next;
    timer_res_t         res_reg, res_next;
    timer_entry_t       rd_data_reg;

    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    timer_entry_t       wr_data;
    logic               cur_used;
    logic               key_match;
    logic               own_match;
    logic               cur_used_after;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    assign cur_used  = used_reg[proc_idx_reg];
    assign own_match = (rd_data_reg.owner == req_reg.owner_id);
    assign key_match = own_match && (rd_data_reg.kind == req_reg.event_kind)
                       && (rd_data_reg.tag == req_reg.timer_tag);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        ff_vld_next     = ff_vld_reg;
        ff_idx_next     = ff_idx_reg;
        found_next      = found_reg;
        pend_vld_next   = pend_vld_reg;
        pend_next       = pend_reg;
        res_vld_next    = 1'b0;
        res_next        = res_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = proc_idx_reg;
        wr_data         = rd_data_reg;
        cur_used_after  = cur_used;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next        = cmd;
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    ff_vld_next     = 1'b0;
                    found_next      = 1'b0;
                    pend_vld_next   = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Read side: issue one slot address per cycle.
                if (!issue_done_reg)
                begin
                    rd_en = 1'b1;
                    if (rd_idx_reg == LAST_IDX)
                        issue_done_next = 1'b1;
                    else
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                end

                // Processing side: the slot read in the previous cycle.
                if (proc_vld_reg)
                begin
                    case (req_reg.action)
                        ACT_SCHEDULE, ACT_CANCEL:
                        begin
                            if (cur_used && key_match)
                                cur_used_after = 1'b0;
                        end
                        ACT_CANCEL_OWN:
                        begin
                            if (cur_used && own_match)
                                cur_used_after = 1'b0;
                        end
                        ACT_QUERY:
                        begin
                            if (cur_used && key_match)
                                found_next = 1'b1;
                        end
                        ACT_TICK:
                        begin
                            if (cur_used)
                            begin
                                if (rd_data_reg.count != '0)
                                begin
                                    wr_en         = 1'b1;
                                    wr_data.count = rd_data_reg.count - 31'd1;
                                end
                                else
                                begin
                                    cur_used_after = 1'b0;
                                    // Hold one fired timer back so the final one can be marked.
                                    if (pend_vld_reg)
                                    begin
                                        res_vld_next = 1'b1;
                                        res_next     = '{RES_FIRED, pend_reg.owner,
                                                         pend_reg.kind, pend_reg.tag,
                                                         1'b0, 1'b0};
                                    end
                                    pend_vld_next = 1'b1;
                                    pend_next     = rd_data_reg;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    used_next[proc_idx_reg] = cur_used_after;
                    if (!cur_used_after && !ff_vld_reg)
                    begin
                        ff_vld_next = 1'b1;
                        ff_idx_next = proc_idx_reg;
                    end
                    if (proc_idx_reg == LAST_IDX)
                        state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                res_vld_next = 1'b1;
                res_next     = '{RES_DONE, 32'd0, 5'd0, 32'd0, 1'b0, 1'b1};
                case (req_reg.action)
                    ACT_SCHEDULE, ACT_ADD:
                    begin
                        if (ff_vld_reg)
                        begin
                            wr_en              = 1'b1;
                            wr_idx             = ff_idx_reg;
                            wr_data            = '{req_reg.owner_id, req_reg.event_kind,
                                                   req_reg.timer_tag, req_reg.start_count};
                            used_next[ff_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            res_next.result_kind = RES_FULL;
                        end
                    end
                    ACT_QUERY:
                    begin
                        res_next.result_kind = RES_QUERY;
                        res_next.match_found = found_reg;
                    end
                    ACT_TICK:
                    begin
                        if (pend_vld_reg)
                            res_next = '{RES_FIRED, pend_reg.owner, pend_reg.kind,
                                         pend_reg.tag, 1'b0, 1'b1};
                        else
                            res_next.result_kind = RES_QUIET;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        proc_vld_next = rd_en;
        proc_idx_next = rd_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= entry_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            issue_done_reg <= 1'b0;
            proc_vld_reg   <= 1'b0;
            ff_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            pend_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            proc_idx_reg   <= '0;
            ff_idx_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            issue_done_reg <= issue_done_next;
            proc_vld_reg   <= proc_vld_next;
            ff_vld_reg     <= ff_vld_next;
            found_reg      <= found_next;
            pend_vld_reg   <= pend_vld_next;
            res_vld_reg    <= res_vld_next;
            rd_idx_reg     <= rd_idx_next;
            proc_idx_reg   <= proc_idx_next;
            ff_idx_reg     <= ff_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    // An accepted transaction keeps the block busy for the following cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // The final result of a transaction appears once the block is free again.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("final result shown while busy");

    // Results that are not final only occur mid-walk.
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy && result.result_kind == RES_FIRED)
        else $error("non-final result outside a tick walk");

    // A slot is only processed while walking the table.
    a_proc_scan: assert property (@(posedge clk) disable iff (!rst_n)
        proc_vld_reg |-> state_reg == ST_SCAN)
        else $error("slot processed outside the walk");

endmodule
